// ===== hdl/rws_pkg.sv =====
// ----------------------------------------------------------------------------
// rws_pkg
// Shared types and constants for the roulette wheel selector.
// ----------------------------------------------------------------------------
package rws_pkg;

    localparam int MAX_POP = 128;              // entries held in the cell ring
    localparam int IDX_W   = $clog2(MAX_POP);  // entry index width
    localparam int CNT_W   = IDX_W + 1;        // population count width
    localparam int FIT_W   = 32;               // fitness, 16 fraction bits
    localparam int FRAC_W  = 16;               // random fraction width
    localparam int TOT_W   = FIT_W + IDX_W;    // exact sum of all entries
    localparam int PROD_W  = TOT_W + FRAC_W;   // fraction * total
    localparam int ADDR_W  = 3;                // APB byte address width
    localparam int DATA_W  = 32;               // APB data width

    localparam logic [CNT_W-1:0] POP_RESET = CNT_W'(100);

    // register index, taken from paddr[ADDR_W-1]
    localparam logic REG_IDX_POP = 1'b0;

    // item kinds
    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_SELECT = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [IDX_W-1:0]  entry_index;
        logic [FIT_W-1:0]  fitness_value;
        logic [FRAC_W-1:0] random_fraction;
    } t_in_beat;

    typedef struct packed {
        logic [IDX_W-1:0] selected_index;
        logic             load_rejected;
    } t_out_beat;

    // controller to scan unit
    typedef struct packed {
        logic             start;  // latch slice, clear running sum
        logic             step;   // one entry at the ring head
        logic [IDX_W-1:0] pos;    // index of the entry at the ring head
    } t_scan_ctl;

endpackage

// ===== hdl/rws_cell.sv =====
// ----------------------------------------------------------------------------
// rws_cell
// One fitness entry of the ring; takes its neighbour's value on each shift.
// ----------------------------------------------------------------------------
module rws_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_shift,
    input  logic [rws_pkg::FIT_W-1:0]  i_d,
    output logic [rws_pkg::FIT_W-1:0]  o_q
);
    import rws_pkg::*;

    logic [FIT_W-1:0] r_q;
    logic [FIT_W-1:0] n_q;

    assign n_q = i_shift ? i_d : r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

// ===== hdl/rws_scan.sv =====
// ----------------------------------------------------------------------------
// rws_scan
// Slice computation and running-sum search over the entries leaving the ring.
// ----------------------------------------------------------------------------
module rws_scan (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  rws_pkg::t_scan_ctl         i_ctl,
    input  logic [rws_pkg::FRAC_W-1:0] i_frac,
    input  logic [rws_pkg::TOT_W-1:0]  i_total,
    input  logic [rws_pkg::FIT_W-1:0]  i_head,
    input  logic [rws_pkg::CNT_W-1:0]  i_count,
    output logic [rws_pkg::IDX_W-1:0]  o_pick
);
    import rws_pkg::*;

    logic [TOT_W-1:0]  r_slice;
    logic [TOT_W-1:0]  r_sum;
    logic              r_found;
    logic [IDX_W-1:0]  r_pick;

    logic [PROD_W-1:0] w_prod;
    logic [TOT_W-1:0]  w_sum;
    logic              w_live;

    assign w_prod = PROD_W'(i_frac) * PROD_W'(i_total);
    assign w_sum  = r_sum + TOT_W'(i_head);
    // only entries below the population count take part, up to the first hit
    assign w_live = i_ctl.step && !r_found && ({1'b0, i_ctl.pos} < i_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_ctl.start) begin
            r_found <= 1'b0;
        end else if (w_live && (w_sum >= r_slice)) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_slice <= w_prod[PROD_W-1:FRAC_W];
            r_sum   <= '0;
            r_pick  <= IDX_W'(i_count - CNT_W'(1));  // slice never reached
        end else if (w_live) begin
            r_sum <= w_sum;
            if (w_sum >= r_slice) begin
                r_pick <= i_ctl.pos;
            end
        end
    end

    assign o_pick = r_pick;

endmodule

// ===== hdl/roulette_wheel_selector_core.sv =====
// ----------------------------------------------------------------------------
// roulette_wheel_selector_core
// Fitness-proportionate selection over a ring of 128 fitness cells.
// ----------------------------------------------------------------------------
// Sequence: a select runs the slice multiply, one ring revolution and the
//   push into the output register; an accepted load skips the multiply;
//   a rejected load goes straight to the push. One item at a time: a full
//   ring revolution per accepted load or select, and no new item is taken
//   until the last one is pushed; the push waits while the output
//   register holds a beat that is not taken.
// Reset (sync, active low): all cells and the total cleared, population
//   count back to 100, output empty, ready for input.
// ----------------------------------------------------------------------------
module roulette_wheel_selector_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input beats
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  rws_pkg::t_in_beat           i_in_beat,
    // result beats
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output rws_pkg::t_out_beat          o_out_beat,
    // APB configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rws_pkg::ADDR_W-1:0]  paddr,
    input  logic [rws_pkg::DATA_W-1:0]  pwdata,
    output logic [rws_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import rws_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,   // slice = (fraction * total) >> 16
        S_RUN  = 4'b0100,   // one ring revolution
        S_PUSH = 4'b1000    // hand result to the output register
    } t_state;

    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_pos, n_pos;
    logic               r_kind;
    logic [IDX_W-1:0]   r_idx;
    logic [FIT_W-1:0]   r_fit;
    logic [FRAC_W-1:0]  r_frac;
    logic               r_rej, n_rej;
    logic [TOT_W-1:0]   r_total, n_total;
    logic [CNT_W-1:0]   r_pop;
    logic               r_out_valid, n_out_valid;
    t_out_beat          r_out_beat, n_out_beat;

    logic               w_in_acc;
    logic               w_out_free;
    logic               w_last;
    logic               w_hit;
    logic               w_shift;
    logic               w_cfg_wr;
    logic [CNT_W-1:0]   w_count;
    logic [FIT_W-1:0]   w_head;
    logic [FIT_W-1:0]   w_tail;
    logic [IDX_W-1:0]   w_pick;
    t_scan_ctl          w_ctl;
    logic [FIT_W-1:0]   w_q [MAX_POP];

    // ------------------------------------------------------------------
    // Configuration: population count, clamped to 1..MAX_POP for use
    // ------------------------------------------------------------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready
                      && (paddr[ADDR_W-1] == REG_IDX_POP);
    assign prdata   = (paddr[ADDR_W-1] == REG_IDX_POP) ? DATA_W'(r_pop) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pop <= POP_RESET;
        end else if (w_cfg_wr) begin
            r_pop <= pwdata[CNT_W-1:0];
        end
    end

    always_comb begin
        if (r_pop == '0) begin
            w_count = CNT_W'(1);
        end else if (r_pop > CNT_W'(MAX_POP)) begin
            w_count = CNT_W'(MAX_POP);
        end else begin
            w_count = r_pop;
        end
    end

    // ------------------------------------------------------------------
    // Cell ring. Each shift moves every entry one cell towards the head;
    // after MAX_POP shifts the ring is back in index order. During the
    // revolution the head holds entry r_pos. A load swaps its new value
    // in at the tail as the addressed entry goes round.
    // ------------------------------------------------------------------
    assign w_shift = (r_state == S_RUN);
    assign w_head  = w_q[0];
    assign w_hit   = (r_kind == KIND_LOAD) && (r_pos == r_idx);
    assign w_tail  = w_hit ? r_fit : w_head;

    for (genvar g = 0; g < MAX_POP; g++) begin : g_cell
        if (g == MAX_POP - 1) begin : g_tail
            rws_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_shift),
                .i_d     (w_tail),
                .o_q     (w_q[g])
            );
        end else begin : g_body
            rws_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_shift),
                .i_d     (w_q[g+1]),
                .o_q     (w_q[g])
            );
        end
    end

    // ------------------------------------------------------------------
    // Scan unit: accumulates the head entry at each ring shift of a select
    // ------------------------------------------------------------------
    assign w_ctl.start = (r_state == S_MUL);
    assign w_ctl.step  = (r_state == S_RUN) && (r_kind == KIND_SELECT);
    assign w_ctl.pos   = r_pos;

    rws_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_frac  (r_frac),
        .i_total (r_total),
        .i_head  (w_head),
        .i_count (w_count),
        .o_pick  (w_pick)
    );

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_last     = (r_pos == IDX_W'(MAX_POP - 1));

    always_comb begin
        n_state = r_state;
        n_pos   = r_pos;
        n_rej   = r_rej;
        n_total = r_total;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_rej = 1'b0;
                    if (i_in_beat.kind == KIND_SELECT) begin
                        n_state = S_MUL;
                    end else if ({1'b0, i_in_beat.entry_index} >= w_count) begin
                        n_rej   = 1'b1;   // store and total untouched
                        n_state = S_PUSH;
                    end else begin
                        n_state = S_RUN;
                    end
                end
            end
            S_MUL: begin
                n_state = S_RUN;
            end
            S_RUN: begin
                n_pos = r_pos + IDX_W'(1);
                if (w_hit) begin
                    n_total = r_total - TOT_W'(w_head) + TOT_W'(r_fit);
                end
                if (w_last) begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pos   <= '0;
            r_total <= '0;
            r_rej   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_total <= n_total;
            r_rej   <= n_rej;
        end
    end

    // item capture, payload only
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_kind <= i_in_beat.kind;
            r_idx  <= i_in_beat.entry_index;
            r_fit  <= i_in_beat.fitness_value;
            r_frac <= i_in_beat.random_fraction;
        end
    end

    // ------------------------------------------------------------------
    // Output register: holds a finished beat while the next item runs
    // ------------------------------------------------------------------
    always_comb begin
        n_out_valid = r_out_valid;
        n_out_beat  = r_out_beat;
        if ((r_state == S_PUSH) && w_out_free) begin
            n_out_valid                = 1'b1;
            n_out_beat.selected_index  = (r_kind == KIND_SELECT) ? w_pick : '0;
            n_out_beat.load_rejected   = r_rej;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_beat <= n_out_beat;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

endmodule

// ===== hdl/rws_chk.sv =====
// ----------------------------------------------------------------------------
// rws_chk
// Port-level checks for roulette_wheel_selector_core, bound to the top level.
// ----------------------------------------------------------------------------
module rws_chk (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                o_in_ready,
    input  logic                o_out_valid,
    input  logic                i_out_ready,
    input  rws_pkg::t_out_beat  o_out_beat
);
    import rws_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_beat))
        else $error("result beat dropped or changed while stalled");

    // a rejected load never carries an index
    a_rej_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_beat.load_rejected |-> o_out_beat.selected_index == '0)
        else $error("rejected load with non-zero index");

    // reset empties the output and leaves the block ready
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("state after reset wrong");

    // one item at a time: busy right after an input beat
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second input beat taken while busy");

endmodule

bind roulette_wheel_selector_core rws_chk u_rws_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_beat  (o_out_beat)
);

// ===== test/roulette_wheel_selector_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// roulette_wheel_selector_checker
// Watches the beat channels and the APB port of the selector, keeps its own
// copy of the fitness cells, the total and the population count, and checks
// every result beat against the oldest predicted one.
// ----------------------------------------------------------------------------
module roulette_wheel_selector_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  rws_pkg::t_in_beat           i_in_beat,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  rws_pkg::t_out_beat          i_out_beat,
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic [rws_pkg::ADDR_W-1:0]  i_paddr,
    input  logic [rws_pkg::DATA_W-1:0]  i_pwdata,
    input  logic [rws_pkg::DATA_W-1:0]  i_prdata,
    input  logic                        i_pready,
    output int                          o_fail_count,
    output int                          o_owed
);
    import rws_pkg::*;

    logic [FIT_W-1:0] fitness_cells [MAX_POP];
    logic [TOT_W-1:0] wheel_total;
    logic [CNT_W-1:0] pop_count;
    t_out_beat        owed_results [$];

    // Apply one accepted beat to the model state and return its result.
    function automatic t_out_beat wheel_outcome(input t_in_beat b);
        t_out_beat         r;
        int unsigned       span;
        logic [PROD_W-1:0] prod;
        logic [TOT_W-1:0]  slice;
        logic [63:0]       running;
        logic              found;
        r = '0;
        // count of 0 behaves as 1, anything past the ring as the full ring
        if (pop_count == '0) begin
            span = 1;
        end else if (pop_count > MAX_POP) begin
            span = MAX_POP;
        end else begin
            span = pop_count;
        end
        if (b.kind == KIND_LOAD) begin
            if (b.entry_index >= span) begin
                r.load_rejected = 1'b1;
            end else begin
                wheel_total = wheel_total - TOT_W'(fitness_cells[b.entry_index])
                              + TOT_W'(b.fitness_value);
                fitness_cells[b.entry_index] = b.fitness_value;
            end
        end else begin
            prod  = PROD_W'(b.random_fraction) * PROD_W'(wheel_total);
            slice = prod[PROD_W-1:FRAC_W];
            // slice not reached (fitness above the count): last scanned entry
            r.selected_index = IDX_W'(span - 1);
            running = '0;
            found   = 1'b0;
            for (int i = 0; i < span; i++) begin
                if (!found) begin
                    running = running + 64'(fitness_cells[i]);
                    if (running >= 64'(slice)) begin
                        r.selected_index = IDX_W'(i);
                        found = 1'b1;
                    end
                end
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_beat want;
        if (!i_rst_n) begin
            foreach (fitness_cells[i]) fitness_cells[i] = '0;
            wheel_total  = '0;
            pop_count    = POP_RESET;
            o_fail_count = 0;
            owed_results.delete();
        end else begin
            if (i_psel && i_penable && i_pready && i_paddr[ADDR_W-1] == REG_IDX_POP) begin
                if (i_pwrite) begin
                    pop_count = i_pwdata[CNT_W-1:0];
                end else if (i_prdata !== DATA_W'(pop_count)) begin
                    $display("%0t: population count read: expected %0d, got %0d",
                             $time, pop_count, i_prdata);
                    o_fail_count++;
                end
            end
            // results first: a beat accepted this edge cannot have its result yet
            if (i_out_valid && i_out_ready) begin
                if (owed_results.size() == 0) begin
                    $display("%0t: unexpected result beat: expected none, got index %0d rej %0b",
                             $time, i_out_beat.selected_index, i_out_beat.load_rejected);
                    o_fail_count++;
                end else begin
                    want = owed_results.pop_front();
                    if (i_out_beat.selected_index !== want.selected_index) begin
                        $display("%0t: selected_index: expected %0d, got %0d",
                                 $time, want.selected_index, i_out_beat.selected_index);
                        o_fail_count++;
                    end
                    if (i_out_beat.load_rejected !== want.load_rejected) begin
                        $display("%0t: load_rejected: expected %0b, got %0b",
                                 $time, want.load_rejected, i_out_beat.load_rejected);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                owed_results.push_back(wheel_outcome(i_in_beat));
            end
        end
        o_owed = owed_results.size();
    end

endmodule

// ===== test/roulette_wheel_selector_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// roulette_wheel_selector_core_tb
// Drives load and select beats and APB writes into the selector. A directed
// run covers empty wheels, rejected loads, extreme fitness and fractions and
// out-of-range population counts; four random phases follow with varied
// idling on both channels. The checker predicts and compares.
// ----------------------------------------------------------------------------
module roulette_wheel_selector_core_tb;
    import rws_pkg::*;

    // population count register, index 0
    localparam logic [ADDR_W-1:0] POP_ADDR = {REG_IDX_POP, {(ADDR_W-1){1'b0}}};
    localparam int HOLD_CYCLES  = 600;         // long receiver hold-off
    localparam int DRAIN_CYCLES = 140;         // extra idle clocks after the final drain
    localparam int PHASE_ITEMS  = 150;
    localparam int RUN_LIMIT_NS = 10_000_000;  // hard stop, far above a clean run

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    t_in_beat          i_in_beat;
    logic              o_out_valid;
    logic              i_out_ready;
    t_out_beat         o_out_beat;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int               fail_count;
    int               owed;
    int               send_idle_pct = 0;   // chance in 100 of a sender gap cycle
    int               stall_pct     = 0;   // chance in 100 of a receiver stall cycle
    logic             hold_req      = 1'b0; // toggles once per hold request
    logic [CNT_W-1:0] cur_pop       = POP_RESET;

    roulette_wheel_selector_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_beat   (i_in_beat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_beat  (o_out_beat),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    roulette_wheel_selector_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_beat    (i_in_beat),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_beat   (o_out_beat),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_prdata     (prdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_owed       (owed)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case a handshake never completes.
    initial begin
        #(RUN_LIMIT_NS);
        $display("roulette_wheel_selector_core: mismatch");
        $finish;
    end

    // Result side. Random stalls per stall_pct; a toggle of hold_req blocks
    // the output for HOLD_CYCLES so the block backs up and drops o_in_ready.
    initial begin
        int   hold_left;
        logic hold_seen;
        hold_left   = 0;
        hold_seen   = 1'b0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    function automatic t_in_beat beat_of(input logic k, input int unsigned idx,
                                         input logic [FIT_W-1:0] fit,
                                         input logic [FRAC_W-1:0] frac);
        t_in_beat b;
        b.kind            = k;
        b.entry_index     = IDX_W'(idx);
        b.fitness_value   = fit;
        b.random_fraction = frac;
        return b;
    endfunction

    // Random beat. Loads mostly land inside the live population so the wheel
    // fills up; the odd one goes anywhere to hit the reject path. Fitness
    // mixes full range, small values and the two extremes.
    function automatic t_in_beat random_beat();
        t_in_beat    b;
        int unsigned span;
        if (cur_pop == '0) begin
            span = 1;
        end else if (cur_pop > MAX_POP) begin
            span = MAX_POP;
        end else begin
            span = cur_pop;
        end
        b.kind = $urandom_range(1) ? KIND_SELECT : KIND_LOAD;
        if ($urandom_range(9) < 8) begin
            b.entry_index = IDX_W'($urandom_range(span - 1));
        end else begin
            b.entry_index = IDX_W'($urandom);
        end
        case ($urandom_range(3))
            0: b.fitness_value = $urandom;
            1: b.fitness_value = $urandom_range(32'h0004_0000);
            2: b.fitness_value = $urandom_range(1) ? '1 : '0;
            default: b.fitness_value = $urandom >> $urandom_range(31);
        endcase
        case ($urandom_range(7))
            0: b.random_fraction = '0;
            1: b.random_fraction = '1;
            default: b.random_fraction = FRAC_W'($urandom);
        endcase
        return b;
    endfunction

    // Offer one beat and hold it until taken. Valid is left high afterwards;
    // the next call or stop_beats decides at the following falling edge, so
    // valid never drops and rises within one step.
    task automatic offer_beat(input t_in_beat b);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_beat  <= b;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic stop_beats();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    // Sender pauses until every owed result is out.
    task automatic drain_results();
        stop_beats();
        while (owed != 0) @(negedge i_clk);
    endtask

    task automatic apb_access(input logic wr, input logic [DATA_W-1:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= POP_ADDR;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Count only changes with the block idle; read back straight after.
    task automatic set_population(input logic [CNT_W-1:0] value);
        drain_results();
        apb_access(1'b1, DATA_W'(value));
        apb_access(1'b0, '0);
        cur_pop = value;
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_beat  = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // ---- directed: reset count of 100 ----
        // empty wheel: zero total, slice 0, always entry 0
        offer_beat(beat_of(KIND_SELECT, 5, '1, '0));
        offer_beat(beat_of(KIND_SELECT, 0, '0, '1));
        offer_beat(beat_of(KIND_LOAD, 0, '1, '0));              // max fitness
        offer_beat(beat_of(KIND_LOAD, 99, 32'h1, '1));          // last live entry
        offer_beat(beat_of(KIND_LOAD, 100, 32'h1234, '0));      // at count: rejected
        offer_beat(beat_of(KIND_LOAD, 127, '1, '0));            // top index: rejected
        offer_beat(beat_of(KIND_LOAD, 50, 32'h0001_0000, '0));
        offer_beat(beat_of(KIND_SELECT, 0, '0, '0));
        offer_beat(beat_of(KIND_SELECT, 0, '0, '1));
        offer_beat(beat_of(KIND_SELECT, 127, '1, 16'h8000));
        offer_beat(beat_of(KIND_LOAD, 0, '0, '0));              // overwrite with zero
        offer_beat(beat_of(KIND_SELECT, 0, '0, '1));

        // count above the ring acts as the full ring
        set_population(8'd255);
        offer_beat(beat_of(KIND_LOAD, 127, '1, '0));
        offer_beat(beat_of(KIND_LOAD, 126, '0, '1));
        offer_beat(beat_of(KIND_SELECT, 0, '0, '1));
        offer_beat(beat_of(KIND_SELECT, 0, '0, 16'h0001));

        // count of zero acts as one; slice beyond entry 0 is never reached
        set_population('0);
        offer_beat(beat_of(KIND_LOAD, 1, 32'h5, '0));           // rejected
        offer_beat(beat_of(KIND_LOAD, 0, 32'h5, '0));
        offer_beat(beat_of(KIND_SELECT, 0, '0, '1));

        // lowered count with fitness still held above it
        set_population(8'd10);
        offer_beat(beat_of(KIND_SELECT, 0, '0, '1));
        offer_beat(beat_of(KIND_LOAD, 9, 32'h0000_8000, '0));
        offer_beat(beat_of(KIND_SELECT, 0, '0, 16'h8000));

        set_population(8'd1);
        offer_beat(beat_of(KIND_LOAD, 0, '1, '0));
        offer_beat(beat_of(KIND_SELECT, 0, '0, '0));

        // ---- random phases ----
        // 0: no idling, 1: sender gaps, 2: receiver stalls, 3: both.
        // Phases 0 and 3 also block the output for a long stretch.
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                    set_population(CNT_W'(MAX_POP));
                end
                1: begin
                    send_idle_pct = 56;
                    stall_pct     = 0;
                    set_population(8'd200);
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct     = 56;
                    set_population(CNT_W'($urandom_range(1, MAX_POP)));
                end
                default: begin
                    send_idle_pct = 15;
                    stall_pct     = 15;
                    set_population(8'd40);
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n == 40 && (p == 0 || p == 3)) begin
                    hold_req = !hold_req;
                end
                if ($urandom_range(39) == 0) begin
                    drain_results();
                end
                offer_beat(random_beat());
            end
        end

        // ---- wind down ----
        drain_results();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("roulette_wheel_selector_core: match");
        end else begin
            $display("roulette_wheel_selector_core: mismatch");
        end
        $finish;
    end

endmodule
